// ----- src/mwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mwg_pkg: shared types, constants and the quarter-wave sine table
// Register indexes, waveform codes, the work-queue word and the
// elaboration-time build of the Q15 quarter sine table.
// ----------------------------------------------------------------------------
package mwg_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_OFFSET = 3'd3;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_NONE     = 2'd3;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // floor(n / d) = (n * ceil(2^64 / d)) >> 64, exact for the operand ranges below
    localparam logic [127:0] RECIP_ANGLE =
        ((128'd1 << 64) + 128'(2 * SINE_TABLE_DEPTH) - 128'd1) / 128'(2 * SINE_TABLE_DEPTH);
    localparam logic [127:0] RECIP_110 = ((128'd1 << 64) + 128'd109) / 128'd110;
    localparam logic [127:0] RECIP_72  = ((128'd1 << 64) + 128'd71) / 128'd72;
    localparam logic [127:0] RECIP_42  = ((128'd1 << 64) + 128'd41) / 128'd42;
    localparam logic [127:0] RECIP_20  = ((128'd1 << 64) + 128'd19) / 128'd20;
    localparam logic [127:0] RECIP_6   = ((128'd1 << 64) + 128'd5) / 128'd6;

    typedef struct packed {
        logic [1:0]         wave_select;
        logic [31:0]        phase_step;
        logic [14:0]        amplitude;
        logic signed [15:0] level_offset;
    } cfg_t;

    // one queued word: the step plus the waveform class it was taken under
    typedef struct packed {
        logic [15:0] time_step;
        logic [1:0]  wave_select;
    } work_t;

    typedef logic [14:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Q15 entry k = sin((2k+1)/(2*depth) * pi/2), integer Q30 series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t    rom;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  s;
        logic [63:0]  v;
        logic [127:0] wide;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            wide = 128'(64'(2 * k + 1) * Q30_HALF_PI) * RECIP_ANGLE;
            x    = wide[127:64];
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            wide = 128'((x2 * term) >> 30) * RECIP_110;
            term = Q30_ONE - wide[127:64];
            wide = 128'((x2 * term) >> 30) * RECIP_72;
            term = Q30_ONE - wide[127:64];
            wide = 128'((x2 * term) >> 30) * RECIP_42;
            term = Q30_ONE - wide[127:64];
            wide = 128'((x2 * term) >> 30) * RECIP_20;
            term = Q30_ONE - wide[127:64];
            wide = 128'((x2 * term) >> 30) * RECIP_6;
            term = Q30_ONE - wide[127:64];
            s    = (x * term) >> 30;
            v    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            rom[k] = v[14:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- src/mwg_step_if.sv -----
// ----------------------------------------------------------------------------
// mwg_step_if: time step channel
// Valid/ready channel carrying one elapsed time step per word.
// ----------------------------------------------------------------------------
interface mwg_step_if;
    logic        valid;
    logic        ready;
    logic [15:0] time_step;

    modport source (output valid, output time_step, input ready);
    modport sink   (input valid, input time_step, output ready);
endinterface

// ----- src/mwg_sample_if.sv -----
// ----------------------------------------------------------------------------
// mwg_sample_if: sample channel
// Valid/ready channel carrying one signed 16-bit sample per word.
// ----------------------------------------------------------------------------
interface mwg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// ----- src/mwg_front.sv -----
// ----------------------------------------------------------------------------
// mwg_front: input side and work queue
// Takes time step words, tags each with the active waveform class and
// holds them in a short queue for the sample engine.
// ----------------------------------------------------------------------------
module mwg_front (
    input  logic                clk,
    input  logic                rst_n,
    mwg_step_if.sink            step_chan,
    input  mwg_pkg::cfg_t       cfg,
    output logic                q_valid,
    output mwg_pkg::work_t      q_head,
    input  logic                q_pop
);

    mwg_pkg::work_t                     entry_reg [mwg_pkg::QUEUE_DEPTH];
    logic [mwg_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [mwg_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [mwg_pkg::QCNT_W-1:0]         count_reg, count_next;
    logic                               push;
    logic                               pop;
    mwg_pkg::work_t                     new_word;

    assign step_chan.ready = (count_reg != mwg_pkg::QCNT_W'(mwg_pkg::QUEUE_DEPTH));
    assign push    = step_chan.valid && step_chan.ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_word.time_step   = step_chan.time_step;
        new_word.wave_select = cfg.wave_select;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mwg_pkg::QPTR_W'(mwg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mwg_pkg::QPTR_W'(mwg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_word;
        end
    end

endmodule

// ----- src/mwg_back.sv -----
// ----------------------------------------------------------------------------
// mwg_back: sample engine
// Sequencer that advances the phase, looks up or shapes the waveform,
// scales by the amplitude, adds the offset and saturates into the
// output register.
// ----------------------------------------------------------------------------
module mwg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mwg_pkg::cfg_t       cfg,
    input  logic                clear_phase,
    input  logic                q_valid,
    input  mwg_pkg::work_t      q_head,
    output logic                q_pop,
    mwg_sample_if.source        sample_chan
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_IDX   = 3'd2;
    localparam logic [2:0] ST_ROM   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [31:0]                prod_reg;
    logic [31:0]                phase_reg;
    logic [1:0]                 mode_reg;
    logic [1:0]                 quad_reg;
    logic [mwg_pkg::IDX_W-1:0]  k_reg;
    logic [31:0]                tri_q_reg;
    logic [14:0]                rom_reg;
    logic [46:0]                mult_reg;
    logic                       out_valid_reg;
    logic signed [15:0]         out_value_reg;

    logic [47:0]                step_prod;
    logic [63:0]                k_mul;
    logic [mwg_pkg::IDX_W-1:0]  k_raw;
    logic [mwg_pkg::IDX_W-1:0]  k_sel;
    logic [32:0]                tri_wrap;
    logic [31:0]                tri_q;
    logic [31:0]                mult_b;
    logic [46:0]                mult_next;
    logic [47:0]                sine_round;
    logic [47:0]                tri_round;
    logic [15:0]                sine_mag;
    logic [16:0]                tri_drop;
    logic signed [17:0]         dev;
    logic signed [17:0]         sum;
    logic signed [15:0]         sample;
    logic                       out_load;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    assign step_prod = 48'(q_head.time_step) * 48'(cfg.phase_step);

    // quarter-wave index: k = pos * depth / 2^30, mirrored in odd quadrants
    assign k_mul = 64'(phase_reg[29:0]) * 64'(mwg_pkg::SINE_TABLE_DEPTH);
    assign k_raw = k_mul[30 +: mwg_pkg::IDX_W];
    assign k_sel = phase_reg[30]
                   ? mwg_pkg::IDX_W'(mwg_pkg::SINE_TABLE_DEPTH - 1) - k_raw : k_raw;

    assign tri_wrap = 33'h1_0000_0000 - {1'b0, phase_reg};
    assign tri_q    = phase_reg[31] ? tri_wrap[31:0] : phase_reg;

    assign mult_b    = (mode_reg == mwg_pkg::WAVE_TRIANGLE) ? tri_q_reg : {17'd0, rom_reg};
    assign mult_next = 47'(cfg.amplitude) * 47'(mult_b);

    assign sine_round = {1'b0, mult_reg} + 48'd16384;
    assign sine_mag   = sine_round[30:15];
    assign tri_round  = {1'b0, mult_reg} + 48'h0000_2000_0000;
    assign tri_drop   = tri_round[46:30];

    always_comb
    begin
        unique case (mode_reg)
            mwg_pkg::WAVE_SINE:
                dev = quad_reg[1] ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});
            mwg_pkg::WAVE_SQUARE:
                dev = phase_reg[31] ? -$signed({3'b000, cfg.amplitude})
                                    : $signed({3'b000, cfg.amplitude});
            mwg_pkg::WAVE_TRIANGLE:
                dev = $signed({3'b000, cfg.amplitude}) - $signed({1'b0, tri_drop});
            default:
                dev = '0;
        endcase
    end

    assign sum = 18'(cfg.level_offset) + dev;

    always_comb
    begin
        if (mode_reg == mwg_pkg::WAVE_NONE)
        begin
            sample = '0;
        end
        else if (sum > 18'sd32767)
        begin
            sample = 16'sh7FFF;
        end
        else if (sum < -18'sd32768)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = sum[15:0];
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || sample_chan.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_ACC;
            ST_ACC:   state_next = ST_IDX;
            ST_IDX:   state_next = ST_ROM;
            ST_ROM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_phase)
            begin
                phase_reg <= '0;
            end
            else if (state_reg == ST_ACC)
            begin
                phase_reg <= phase_reg + prod_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sample_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_reg <= step_prod[31:0];
            mode_reg <= q_head.wave_select;
        end
        if (state_reg == ST_IDX)
        begin
            quad_reg  <= phase_reg[31:30];
            k_reg     <= k_sel;
            tri_q_reg <= tri_q;
        end
        if (state_reg == ST_ROM)
        begin
            rom_reg <= mwg_pkg::SINE_ROM[k_reg];
        end
        if (state_reg == ST_SCALE)
        begin
            mult_reg <= mult_next;
        end
        if (out_load)
        begin
            out_value_reg <= sample;
        end
    end

    assign sample_chan.valid        = out_valid_reg;
    assign sample_chan.sample_value = out_value_reg;

    a_pop_enters_acc: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_ACC))
        else $error("popped word did not start the phase update");

    a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_pop)
        else $error("queue popped while a word is in progress");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROM) |-> (32'(k_reg) < 32'(mwg_pkg::SINE_TABLE_DEPTH)))
        else $error("sine table index out of range");

    a_none_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (mode_reg == mwg_pkg::WAVE_NONE)) |=> (out_value_reg == 16'sd0))
        else $error("silent mode produced a nonzero sample");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded sample not presented");

endmodule

// ----- src/multi_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_generator: DDS sine / square / triangle generator
// Config registers, input queue and sample engine.
// ----------------------------------------------------------------------------
// Usage:
//   step_chan carries one time_step word per sample request; sample_chan
//   returns one saturated signed 16-bit sample per request, in order.
//   The write port sets wave_select (0), phase_step (1), amplitude (2) and
//   level_offset (3); a write to any of these clears the phase, a write to
//   a higher index is ignored. Write only while no request is in flight.
//   The sample engine takes one word from the queue at a time and runs it
//   through its sequence (step multiply, phase add, index, table read,
//   scale, output) before it takes the next word.
//   The two-word queue takes new steps while the engine works.
//   Reset clears the phase, the config registers and the queue; the sine table
//   is a constant ROM and needs no fill.
//   When the receiver stalls, the sample waits in the output register,
//   the engine holds in its last step and the queue fills, after which
//   step_chan.ready drops.
// ----------------------------------------------------------------------------
module multi_waveform_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    mwg_step_if.sink                            step_chan,
    mwg_sample_if.source                        sample_chan,
    input  logic                                cfg_write_en,
    input  logic [mwg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mwg_pkg::cfg_t  cfg_reg, cfg_next;
    logic           clear_phase;
    logic           q_valid;
    logic           q_pop;
    mwg_pkg::work_t q_head;

    always_comb
    begin
        cfg_next    = cfg_reg;
        clear_phase = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                mwg_pkg::REG_WAVE_SELECT:
                begin
                    cfg_next.wave_select = cfg_data[1:0];
                    clear_phase          = 1'b1;
                end
                mwg_pkg::REG_PHASE_STEP:
                begin
                    cfg_next.phase_step = cfg_data[31:0];
                    clear_phase         = 1'b1;
                end
                mwg_pkg::REG_AMPLITUDE:
                begin
                    cfg_next.amplitude = cfg_data[14:0];
                    clear_phase        = 1'b1;
                end
                mwg_pkg::REG_LEVEL_OFFSET:
                begin
                    cfg_next.level_offset = cfg_data[15:0];
                    clear_phase           = 1'b1;
                end
                default:
                begin
                    clear_phase = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mwg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_chan (step_chan),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    mwg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear_phase (clear_phase),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .sample_chan (sample_chan)
    );

endmodule
